[rtl/dcfr_pkg.sv]
`timescale 1ns / 1ps

package dcfr_pkg;

  // fixed frame layout: command plus 16-bit reference ahead of the forwarded part
  localparam int MSG_BYTES = 3;
  // status, two data bytes and the stop byte appended to every forwarded frame
  localparam int TAIL_BYTES = 4;

  localparam logic [7:0] STOP_BYTE_RESET = 8'd126;
  localparam logic [7:0] SET_CURRENT_OPCODE_RESET = 8'd1;

  // register indexes on the configuration port
  localparam logic REG_STOP_BYTE = 1'b0;
  localparam logic REG_SET_CURRENT_OPCODE = 1'b1;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_frame;
    logic        set_current;
    logic [15:0] current_ref;
    logic        frame_error;
    logic        motor_stop;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic drain_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic frame_ok;
    logic drain_last;
  } dp_flags_t;

endpackage

[rtl/dcfr_ctrl.sv]
`timescale 1ns / 1ps

module dcfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  dcfr_pkg::dp_flags_t status,
  output logic                in_stall,
  output dcfr_pkg::cmd_t      cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    cmd.accept     = (state == ST_IDLE) && in_valid && status.out_free;
    cmd.drain_load = (state == ST_DRAIN) && status.out_free;
    in_stall       = !((state == ST_IDLE) && status.out_free);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && status.frame_ok) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cmd.drain_load && status.drain_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/dcfr_datapath.sv]
`timescale 1ns / 1ps

module dcfr_datapath #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dcfr_pkg::cmd_t      cmd,
  input  dcfr_pkg::in_t       in_data,
  input  logic [7:0]          stop_byte,
  input  logic [7:0]          set_current_opcode,
  input  logic                out_stall,
  output dcfr_pkg::dp_flags_t status,
  output logic                out_valid,
  output dcfr_pkg::out_t      out_data
);

  localparam int PAYLOAD   = FRAME_BYTES - 1 - dcfr_pkg::MSG_BYTES;
  localparam int OUT_COUNT = PAYLOAD + dcfr_pkg::TAIL_BYTES;
  localparam int AW        = $clog2(FRAME_BYTES);
  localparam int IDX_W     = $clog2(OUT_COUNT);
  localparam logic [AW-1:0]    LAST_POS = AW'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OUT_COUNT - 1);
  localparam logic [IDX_W-1:0] PAY_END  = IDX_W'(PAYLOAD);

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0]    byte_count;
  logic [IDX_W-1:0] idx;
  logic [7:0]  head0;
  logic [7:0]  head1;
  logic [7:0]  head2;
  logic        setc;
  logic [15:0] cref;
  logic        timeout_flag;
  logic        timeout_flag_next;
  logic [7:0]  frame_counter;
  logic [7:0]  counter_at_last_tick;

  logic completes;
  logic is_byte;
  logic frame_ok;
  logic out_free;

  assign is_byte   = (in_data.mode == dcfr_pkg::MODE_BYTE);
  assign completes = (byte_count == LAST_POS);
  assign frame_ok  = is_byte && completes && (in_data.rx_byte == stop_byte);
  assign out_free  = !out_valid || !out_stall;

  assign status.out_free   = out_free;
  assign status.frame_ok   = frame_ok;
  assign status.drain_last = (idx == LAST_IDX);

  // tick sets the flag when no valid frame landed since the previous tick
  assign timeout_flag_next = (counter_at_last_tick == frame_counter) ? 1'b1 : timeout_flag;

  // address runs one ahead when a drain byte leaves, so the registered read keeps pace
  always_comb begin
    if (cmd.drain_load) begin
      rd_addr = AW'(dcfr_pkg::MSG_BYTES + int'(idx) + 1);
    end else begin
      rd_addr = AW'(dcfr_pkg::MSG_BYTES + int'(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_byte) begin
      mem[byte_count] <= in_data.rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_byte) begin
      if (byte_count == AW'(0)) head0 <= in_data.rx_byte;
      if (byte_count == AW'(1)) head1 <= in_data.rx_byte;
      if (byte_count == AW'(2)) head2 <= in_data.rx_byte;
    end
    if (cmd.accept && frame_ok) begin
      setc <= (head0 == set_current_opcode);
      cref <= (head0 == set_current_opcode) ? {head1, head2} : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count           <= '0;
      idx                  <= '0;
      timeout_flag         <= 1'b1;
      frame_counter        <= 8'd0;
      counter_at_last_tick <= 8'd0;
    end else begin
      if (cmd.accept) begin
        if (!is_byte) begin
          timeout_flag         <= timeout_flag_next;
          counter_at_last_tick <= frame_counter;
        end else if (completes) begin
          byte_count <= '0;
          if (frame_ok) begin
            timeout_flag  <= 1'b0;
            frame_counter <= frame_counter + 8'd1;
          end
        end else begin
          byte_count <= byte_count + AW'(1);
        end
      end
      if (cmd.drain_load) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.drain_load || (cmd.accept && !frame_ok)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      if (idx < PAY_END) begin
        out_data.out_byte <= rd_data;
      end else if (idx == LAST_IDX) begin
        out_data.out_byte <= stop_byte;
      end else begin
        out_data.out_byte <= 8'd0;
      end
      out_data.byte_valid    <= 1'b1;
      out_data.last_of_frame <= (idx == LAST_IDX);
      out_data.set_current   <= setc;
      out_data.current_ref   <= cref;
      out_data.frame_error   <= 1'b0;
      out_data.motor_stop    <= timeout_flag;
    end else if (cmd.accept && !frame_ok) begin
      out_data.out_byte      <= 8'd0;
      out_data.byte_valid    <= 1'b0;
      out_data.last_of_frame <= 1'b1;
      out_data.set_current   <= 1'b0;
      out_data.current_ref   <= 16'd0;
      out_data.frame_error   <= is_byte && completes;
      out_data.motor_stop    <= is_byte ? timeout_flag : timeout_flag_next;
    end
  end

endmodule

[rtl/daisy_chain_frame_relay.sv]
`timescale 1ns / 1ps

// daisy-chain frame relay
// input channel (in_valid / in_stall / in_data) carries either a received byte
// or a watchdog tick; output channel (out_valid / out_stall / out_data) carries
// result transactions. registers stop_byte (0x0) and set_current_opcode (0x4)
// sit on the apb port; write them only while the block is idle.
// a byte that does not finish a frame, a frame without the stop byte and a
// tick each give one result, registered in the cycle after its input.
// a frame ending in the stop byte gives FRAME_BYTES results: the first is
// loaded in the drain state that follows the last byte, then one per cycle
// while the receiver does not stall, paced by the registered read of the
// frame memory feeding the output register. one input transaction is
// handled at a time: the next is taken once the output register is free,
// so single-result items pass straight through when the receiver keeps up,
// and a forwarded frame holds the input until its last result is loaded.
// a stall holds the output register and, behind it, the whole block.
// reset clears the byte count, frame counter and output valid and sets the
// timeout flag, so motor_stop reads high until the first good frame.

module daisy_chain_frame_relay #(
  parameter int FRAME_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dcfr_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dcfr_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [7:0] stop_byte;
  logic [7:0] set_current_opcode;
  dcfr_pkg::cmd_t      cmd;
  dcfr_pkg::dp_flags_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_byte          <= dcfr_pkg::STOP_BYTE_RESET;
      set_current_opcode <= dcfr_pkg::SET_CURRENT_OPCODE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        dcfr_pkg::REG_STOP_BYTE:          stop_byte          <= pwdata[7:0];
        dcfr_pkg::REG_SET_CURRENT_OPCODE: set_current_opcode <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dcfr_pkg::REG_STOP_BYTE:          prdata = {24'd0, stop_byte};
      dcfr_pkg::REG_SET_CURRENT_OPCODE: prdata = {24'd0, set_current_opcode};
      default:                          prdata = 32'd0;
    endcase
  end

  dcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dcfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .in_data            (in_data),
    .stop_byte          (stop_byte),
    .set_current_opcode (set_current_opcode),
    .out_stall          (out_stall),
    .status             (status),
    .out_valid          (out_valid),
    .out_data           (out_data)
  );

  // no input transaction while a frame is being forwarded
  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.drain_load))
    else $error("input accepted during frame drain");

  a_drain_loads_output: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_load |=> out_valid && out_data.byte_valid)
    else $error("drain step did not load a forwarded byte");

  a_forwarded_clears_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_valid |-> !out_data.motor_stop && !out_data.frame_error)
    else $error("forwarded byte with motor stop or error");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_error |-> out_data.last_of_frame && !out_data.set_current)
    else $error("dropped frame result malformed");

endmodule
